@@ design/ipv4l4_pkg.sv @@
// Package for the IPv4 / L4 header extractor: verdict codes, header offsets and the result type.
// It depends on nothing; the core takes its names by package scope.
package ipv4l4_pkg;

  typedef enum logic [1:0] {
    VERDICT_FORWARD = 2'd0,
    VERDICT_PASS    = 2'd1,
    VERDICT_DROP    = 2'd2
  } verdict_t;

  typedef struct packed {
    verdict_t    verdict;
    logic [31:0] source_address;
    logic [31:0] dest_address;
    logic [7:0]  transport_proto;
    logic [15:0] source_port;
    logic [15:0] dest_port;
    logic [31:0] sequence_number;
    logic [31:0] ack_number;
    logic [7:0]  tcp_flag_bits;
  } result_t;

  localparam int unsigned OFFSET_W = 6;

  localparam logic [OFFSET_W-1:0] OFFSET_MAX    = 6'd54;
  localparam logic [OFFSET_W-1:0] LEN_ETHER     = 6'd14;
  localparam logic [OFFSET_W-1:0] LEN_IPV4      = 6'd34;
  localparam logic [OFFSET_W-1:0] LEN_TCP       = 6'd54;
  localparam logic [OFFSET_W-1:0] LEN_UDP       = 6'd42;

  localparam logic [OFFSET_W-1:0] POS_ETYPE_HI  = 6'd12;
  localparam logic [OFFSET_W-1:0] POS_ETYPE_LO  = 6'd13;
  localparam logic [OFFSET_W-1:0] POS_PROTO     = 6'd23;
  localparam logic [OFFSET_W-1:0] POS_SRC_FIRST = 6'd26;
  localparam logic [OFFSET_W-1:0] POS_SRC_LAST  = 6'd29;
  localparam logic [OFFSET_W-1:0] POS_DST_FIRST = 6'd30;
  localparam logic [OFFSET_W-1:0] POS_DST_LAST  = 6'd33;
  localparam logic [OFFSET_W-1:0] POS_SPORT_HI  = 6'd34;
  localparam logic [OFFSET_W-1:0] POS_SPORT_LO  = 6'd35;
  localparam logic [OFFSET_W-1:0] POS_DPORT_HI  = 6'd36;
  localparam logic [OFFSET_W-1:0] POS_DPORT_LO  = 6'd37;
  localparam logic [OFFSET_W-1:0] POS_SEQ_FIRST = 6'd38;
  localparam logic [OFFSET_W-1:0] POS_SEQ_LAST  = 6'd41;
  localparam logic [OFFSET_W-1:0] POS_ACK_FIRST = 6'd42;
  localparam logic [OFFSET_W-1:0] POS_ACK_LAST  = 6'd45;
  localparam logic [OFFSET_W-1:0] POS_FLAGS     = 6'd47;

  localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
  localparam logic [7:0]  PROTO_TCP      = 8'd6;
  localparam logic [7:0]  PROTO_UDP      = 8'd17;

endpackage

@@ design/ipv4_l4_header_extractor_core.sv @@
// Top level of the IPv4 / L4 header extractor: byte counter, header captures and result queue.
// It depends on ipv4l4_pkg for the verdict codes, offsets and the result type.
//
// One frame byte per cycle while the skid is empty; counter and captures update in the accept cycle.
// The last byte's result goes into the result register, or the skid register on an output stall.
// A two-entry output queue (result register plus skid register) lets bytes flow while a result waits.
// Reset clears the byte offset, all captures and both result valid flags.
module ipv4_l4_header_extractor_core (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [7:0]   s_axis_tdata,   // frame_byte[7:0]
  input  logic         s_axis_tlast,   // frame_end
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [183:0] m_axis_tdata    // verdict[1:0], source_address[33:2],
                                       // dest_address[65:34], transport_proto[73:66],
                                       // source_port[89:74], dest_port[105:90],
                                       // sequence_number[137:106], ack_number[169:138],
                                       // tcp_flag_bits[177:170], zero[183:178]
);

  logic [ipv4l4_pkg::OFFSET_W-1:0] byte_offset, byte_offset_next;
  logic [ipv4l4_pkg::OFFSET_W-1:0] frame_len;
  logic [15:0] ether_type, ether_type_next;
  logic [7:0]  proto_capture, proto_capture_next;
  logic [31:0] src_addr_capture, src_addr_capture_next;
  logic [31:0] dst_addr_capture, dst_addr_capture_next;
  logic [15:0] sport_capture, sport_capture_next;
  logic [15:0] dport_capture, dport_capture_next;
  logic [31:0] seq_capture, seq_capture_next;
  logic [31:0] ack_capture, ack_capture_next;
  logic [7:0]  flags_capture, flags_capture_next;

  ipv4l4_pkg::result_t result_next, out_result, skid_result;
  logic out_valid, skid_valid;
  logic accept, push, pop;
  logic is_tcp, is_udp;

  assign s_axis_tready = !skid_valid;
  assign accept = s_axis_tvalid && s_axis_tready;
  assign push = accept && s_axis_tlast;
  assign pop = out_valid && m_axis_tready;
  assign frame_len = byte_offset + 6'd1;

  always_comb begin
    ether_type_next = ether_type;
    proto_capture_next = proto_capture;
    src_addr_capture_next = src_addr_capture;
    dst_addr_capture_next = dst_addr_capture;
    sport_capture_next = sport_capture;
    dport_capture_next = dport_capture;
    seq_capture_next = seq_capture;
    ack_capture_next = ack_capture;
    flags_capture_next = flags_capture;
    if (byte_offset == ipv4l4_pkg::POS_ETYPE_HI || byte_offset == ipv4l4_pkg::POS_ETYPE_LO) begin
      ether_type_next = {ether_type[7:0], s_axis_tdata};
    end else if (byte_offset == ipv4l4_pkg::POS_PROTO) begin
      proto_capture_next = s_axis_tdata;
    end else if (byte_offset >= ipv4l4_pkg::POS_SRC_FIRST
                 && byte_offset <= ipv4l4_pkg::POS_SRC_LAST) begin
      src_addr_capture_next = {src_addr_capture[23:0], s_axis_tdata};
    end else if (byte_offset >= ipv4l4_pkg::POS_DST_FIRST
                 && byte_offset <= ipv4l4_pkg::POS_DST_LAST) begin
      dst_addr_capture_next = {dst_addr_capture[23:0], s_axis_tdata};
    end else if (byte_offset == ipv4l4_pkg::POS_SPORT_HI
                 || byte_offset == ipv4l4_pkg::POS_SPORT_LO) begin
      sport_capture_next = {sport_capture[7:0], s_axis_tdata};
    end else if (byte_offset == ipv4l4_pkg::POS_DPORT_HI
                 || byte_offset == ipv4l4_pkg::POS_DPORT_LO) begin
      dport_capture_next = {dport_capture[7:0], s_axis_tdata};
    end else if (byte_offset >= ipv4l4_pkg::POS_SEQ_FIRST
                 && byte_offset <= ipv4l4_pkg::POS_SEQ_LAST) begin
      seq_capture_next = {seq_capture[23:0], s_axis_tdata};
    end else if (byte_offset >= ipv4l4_pkg::POS_ACK_FIRST
                 && byte_offset <= ipv4l4_pkg::POS_ACK_LAST) begin
      ack_capture_next = {ack_capture[23:0], s_axis_tdata};
    end else if (byte_offset == ipv4l4_pkg::POS_FLAGS) begin
      flags_capture_next = s_axis_tdata;
    end
    byte_offset_next = (byte_offset >= ipv4l4_pkg::OFFSET_MAX) ?
                       ipv4l4_pkg::OFFSET_MAX : frame_len;
  end

  assign is_tcp = proto_capture_next == ipv4l4_pkg::PROTO_TCP;
  assign is_udp = proto_capture_next == ipv4l4_pkg::PROTO_UDP;

  // The verdict sees the captures with the current byte already shifted in.
  always_comb begin
    result_next = '0;
    if (frame_len < ipv4l4_pkg::LEN_ETHER) begin
      result_next.verdict = ipv4l4_pkg::VERDICT_DROP;
    end else if (ether_type_next != ipv4l4_pkg::ETHERTYPE_IPV4) begin
      result_next.verdict = ipv4l4_pkg::VERDICT_PASS;
    end else if (frame_len < ipv4l4_pkg::LEN_IPV4) begin
      result_next.verdict = ipv4l4_pkg::VERDICT_DROP;
    end else if (is_tcp && frame_len < ipv4l4_pkg::LEN_TCP) begin
      result_next.verdict = ipv4l4_pkg::VERDICT_DROP;
    end else if (is_udp && frame_len < ipv4l4_pkg::LEN_UDP) begin
      result_next.verdict = ipv4l4_pkg::VERDICT_DROP;
    end else begin
      result_next.verdict = ipv4l4_pkg::VERDICT_FORWARD;
      result_next.source_address = src_addr_capture_next;
      result_next.dest_address = dst_addr_capture_next;
      result_next.transport_proto = proto_capture_next;
      if (is_tcp || is_udp) begin
        result_next.source_port = sport_capture_next;
        result_next.dest_port = dport_capture_next;
      end
      if (is_tcp) begin
        result_next.sequence_number = seq_capture_next;
        result_next.ack_number = ack_capture_next;
        result_next.tcp_flag_bits = flags_capture_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_offset <= '0;
      ether_type <= '0;
      proto_capture <= '0;
      src_addr_capture <= '0;
      dst_addr_capture <= '0;
      sport_capture <= '0;
      dport_capture <= '0;
      seq_capture <= '0;
      ack_capture <= '0;
      flags_capture <= '0;
    end else if (accept) begin
      if (s_axis_tlast) begin
        byte_offset <= '0;
        ether_type <= '0;
        proto_capture <= '0;
        src_addr_capture <= '0;
        dst_addr_capture <= '0;
        sport_capture <= '0;
        dport_capture <= '0;
        seq_capture <= '0;
        ack_capture <= '0;
        flags_capture <= '0;
      end else begin
        byte_offset <= byte_offset_next;
        ether_type <= ether_type_next;
        proto_capture <= proto_capture_next;
        src_addr_capture <= src_addr_capture_next;
        dst_addr_capture <= dst_addr_capture_next;
        sport_capture <= sport_capture_next;
        dport_capture <= dport_capture_next;
        seq_capture <= seq_capture_next;
        ack_capture <= ack_capture_next;
        flags_capture <= flags_capture_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || pop) begin
      if (skid_valid) begin
        out_valid <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= push;
      end
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || pop) begin
      if (skid_valid) begin
        out_result <= skid_result;
      end else if (push) begin
        out_result <= result_next;
      end
    end else if (push) begin
      skid_result <= result_next;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata = {6'd0,
                         out_result.tcp_flag_bits,
                         out_result.ack_number,
                         out_result.sequence_number,
                         out_result.dest_port,
                         out_result.source_port,
                         out_result.transport_proto,
                         out_result.dest_address,
                         out_result.source_address,
                         out_result.verdict};

endmodule

@@ tb/ipv4_l4_result_monitor.sv @@
// Result monitor for the IPv4 / L4 header extractor: predicts one result per frame and checks it.
// It depends on ipv4l4_pkg for the verdict codes, header offsets and the result type.
`timescale 1ns / 100ps

module ipv4_l4_result_monitor (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  input  logic         s_axis_tready,
  input  logic [7:0]   s_axis_tdata,   // frame_byte[7:0]
  input  logic         s_axis_tlast,   // frame_end
  input  logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  input  logic [183:0] m_axis_tdata,   // verdict[1:0], source_address[33:2],
                                       // dest_address[65:34], transport_proto[73:66],
                                       // source_port[89:74], dest_port[105:90],
                                       // sequence_number[137:106], ack_number[169:138],
                                       // tcp_flag_bits[177:170], zero[183:178]
  output int           mismatch_count,
  output int           results_outstanding
);

  ipv4l4_pkg::result_t predicted_results[$];

  logic [ipv4l4_pkg::OFFSET_W-1:0] offset;
  logic [15:0]         etype_cap;
  logic [7:0]          proto_cap;
  logic [31:0]         src_cap;
  logic [31:0]         dst_cap;
  logic [15:0]         sport_cap;
  logic [15:0]         dport_cap;
  logic [31:0]         seq_cap;
  logic [31:0]         ack_cap;
  logic [7:0]          flags_cap;

  task automatic clear_captures();
    offset    = '0;
    etype_cap = '0;
    proto_cap = '0;
    src_cap   = '0;
    dst_cap   = '0;
    sport_cap = '0;
    dport_cap = '0;
    seq_cap   = '0;
    ack_cap   = '0;
    flags_cap = '0;
  endtask

  task automatic compare_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
    if (got !== want) begin
      mismatch_count++;
      if (mismatch_count <= 10) begin
        $display("Mismatch in %s: expected %h, actual %h", name, want, got);
      end
    end
  endtask

  task automatic predict_byte(input logic [7:0] b, input logic last);
    logic [6:0] len;
    ipv4l4_pkg::result_t res;
    len = {1'b0, offset} + 7'd1;
    if (offset == ipv4l4_pkg::POS_ETYPE_HI || offset == ipv4l4_pkg::POS_ETYPE_LO) begin
      etype_cap = {etype_cap[7:0], b};
    end else if (offset == ipv4l4_pkg::POS_PROTO) begin
      proto_cap = b;
    end else if (offset >= ipv4l4_pkg::POS_SRC_FIRST
                 && offset <= ipv4l4_pkg::POS_SRC_LAST) begin
      src_cap = {src_cap[23:0], b};
    end else if (offset >= ipv4l4_pkg::POS_DST_FIRST
                 && offset <= ipv4l4_pkg::POS_DST_LAST) begin
      dst_cap = {dst_cap[23:0], b};
    end else if (offset == ipv4l4_pkg::POS_SPORT_HI
                 || offset == ipv4l4_pkg::POS_SPORT_LO) begin
      sport_cap = {sport_cap[7:0], b};
    end else if (offset == ipv4l4_pkg::POS_DPORT_HI
                 || offset == ipv4l4_pkg::POS_DPORT_LO) begin
      dport_cap = {dport_cap[7:0], b};
    end else if (offset >= ipv4l4_pkg::POS_SEQ_FIRST
                 && offset <= ipv4l4_pkg::POS_SEQ_LAST) begin
      seq_cap = {seq_cap[23:0], b};
    end else if (offset >= ipv4l4_pkg::POS_ACK_FIRST
                 && offset <= ipv4l4_pkg::POS_ACK_LAST) begin
      ack_cap = {ack_cap[23:0], b};
    end else if (offset == ipv4l4_pkg::POS_FLAGS) begin
      flags_cap = b;
    end
    offset = (len > ipv4l4_pkg::OFFSET_MAX) ? ipv4l4_pkg::OFFSET_MAX
                                            : len[ipv4l4_pkg::OFFSET_W-1:0];

    if (last) begin
      res = '0;
      if (len < ipv4l4_pkg::LEN_ETHER) begin
        res.verdict = ipv4l4_pkg::VERDICT_DROP;
      end else if (etype_cap != ipv4l4_pkg::ETHERTYPE_IPV4) begin
        res.verdict = ipv4l4_pkg::VERDICT_PASS;
      end else if (len < ipv4l4_pkg::LEN_IPV4) begin
        res.verdict = ipv4l4_pkg::VERDICT_DROP;
      end else if (proto_cap == ipv4l4_pkg::PROTO_TCP && len < ipv4l4_pkg::LEN_TCP) begin
        res.verdict = ipv4l4_pkg::VERDICT_DROP;
      end else if (proto_cap == ipv4l4_pkg::PROTO_UDP && len < ipv4l4_pkg::LEN_UDP) begin
        res.verdict = ipv4l4_pkg::VERDICT_DROP;
      end else begin
        res.verdict         = ipv4l4_pkg::VERDICT_FORWARD;
        res.source_address  = src_cap;
        res.dest_address    = dst_cap;
        res.transport_proto = proto_cap;
        if (proto_cap == ipv4l4_pkg::PROTO_TCP || proto_cap == ipv4l4_pkg::PROTO_UDP) begin
          res.source_port = sport_cap;
          res.dest_port   = dport_cap;
        end
        if (proto_cap == ipv4l4_pkg::PROTO_TCP) begin
          res.sequence_number = seq_cap;
          res.ack_number      = ack_cap;
          res.tcp_flag_bits   = flags_cap;
        end
      end
      predicted_results.push_back(res);
      clear_captures();
    end
  endtask

  task automatic check_result(input logic [183:0] data);
    ipv4l4_pkg::result_t want;
    if (predicted_results.size() == 0) begin
      mismatch_count++;
      if (mismatch_count <= 10) begin
        $display("Unexpected result %h with no prediction pending", data);
      end
    end else begin
      want = predicted_results.pop_front();
      compare_field("verdict",         {30'd0, want.verdict},       {30'd0, data[1:0]});
      compare_field("source_address",  want.source_address,         data[33:2]);
      compare_field("dest_address",    want.dest_address,           data[65:34]);
      compare_field("transport_proto", {24'd0, want.transport_proto}, {24'd0, data[73:66]});
      compare_field("source_port",     {16'd0, want.source_port},   {16'd0, data[89:74]});
      compare_field("dest_port",       {16'd0, want.dest_port},     {16'd0, data[105:90]});
      compare_field("sequence_number", want.sequence_number,        data[137:106]);
      compare_field("ack_number",      want.ack_number,             data[169:138]);
      compare_field("tcp_flag_bits",   {24'd0, want.tcp_flag_bits}, {24'd0, data[177:170]});
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      clear_captures();
      predicted_results.delete();
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        predict_byte(s_axis_tdata, s_axis_tlast);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        check_result(m_axis_tdata);
      end
    end
    results_outstanding <= predicted_results.size();
  end

endmodule

@@ tb/testbench.sv @@
// Top of the IPv4 / L4 header extractor testbench: clock, reset, frame stimulus and verdict.
// It depends on ipv4l4_pkg, the extractor core and the result monitor.
`timescale 1ns / 100ps

module testbench;

  typedef enum int {FILL_RANDOM, FILL_ZERO, FILL_ONES} fill_t;

  logic         clk;
  logic         rst;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [7:0]   s_axis_tdata;
  logic         s_axis_tlast;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [183:0] m_axis_tdata;
  int           mismatch_count;
  int           results_outstanding;

  int           send_idle_pct;
  int           recv_idle_pct;
  logic         hold_req;
  logic [7:0]   frame_bytes [0:79];

  ipv4_l4_header_extractor_core dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  ipv4_l4_result_monitor monitor (
    .clk                 (clk),
    .rst                 (rst),
    .s_axis_tvalid       (s_axis_tvalid),
    .s_axis_tready       (s_axis_tready),
    .s_axis_tdata        (s_axis_tdata),
    .s_axis_tlast        (s_axis_tlast),
    .m_axis_tvalid       (m_axis_tvalid),
    .m_axis_tready       (m_axis_tready),
    .m_axis_tdata        (m_axis_tdata),
    .mismatch_count      (mismatch_count),
    .results_outstanding (results_outstanding)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  initial begin
    #20_000_000;
    $display("Verification failed");
    $finish;
  end

  // The receiver holds off for one long stretch once requested, otherwise stalls at random.
  initial begin
    logic hold_served;
    hold_served   = 1'b0;
    m_axis_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_served) begin
        m_axis_tready <= 1'b0;
        repeat (300) @(posedge clk);
        hold_served = 1'b1;
      end
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= last;
    do @(posedge clk); while (!s_axis_tready);
  endtask

  task automatic build_frame(input int len, input logic [15:0] etype, input logic [7:0] proto,
                             input fill_t fill);
    for (int i = 0; i < len; i++) begin
      case (fill)
        FILL_ZERO: frame_bytes[i] = 8'h00;
        FILL_ONES: frame_bytes[i] = 8'hFF;
        default:   frame_bytes[i] = 8'($urandom_range(255));
      endcase
    end
    if (len > 12) frame_bytes[12] = etype[15:8];
    if (len > 13) frame_bytes[13] = etype[7:0];
    if (len > 23) frame_bytes[23] = proto;
  endtask

  task automatic send_frame(input int len, input logic [15:0] etype, input logic [7:0] proto,
                            input fill_t fill);
    build_frame(len, etype, proto, fill);
    for (int i = 0; i < len; i++) begin
      send_byte(frame_bytes[i], i == len - 1);
    end
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (results_outstanding != 0) @(posedge clk);
  endtask

  function automatic logic [15:0] other_etype();
    logic [15:0] e;
    do e = 16'($urandom_range(16'hFFFF)); while (e == ipv4l4_pkg::ETHERTYPE_IPV4);
    return e;
  endfunction

  function automatic logic [7:0] other_proto();
    logic [7:0] p;
    do p = 8'($urandom_range(255));
    while (p == ipv4l4_pkg::PROTO_TCP || p == ipv4l4_pkg::PROTO_UDP);
    return p;
  endfunction

  // Mostly well-formed TCP, UDP, other IPv4 and non-IP frames, plus truncated ones and noise.
  task automatic send_random_frames(input int byte_budget);
    int          sent;
    int          len;
    int          pick;
    logic [15:0] etype;
    logic [7:0]  proto;
    sent = 0;
    while (sent < byte_budget) begin
      pick  = $urandom_range(99);
      etype = ipv4l4_pkg::ETHERTYPE_IPV4;
      if (pick < 25) begin
        proto = ipv4l4_pkg::PROTO_TCP;
        len   = $urandom_range(64, 54);
      end else if (pick < 45) begin
        proto = ipv4l4_pkg::PROTO_UDP;
        len   = $urandom_range(50, 42);
      end else if (pick < 57) begin
        proto = other_proto();
        len   = $urandom_range(44, 34);
      end else if (pick < 67) begin
        etype = other_etype();
        proto = 8'($urandom_range(255));
        len   = $urandom_range(40, 14);
      end else if (pick < 82) begin
        case ($urandom_range(3))
          0: begin proto = ipv4l4_pkg::PROTO_TCP; len = $urandom_range(53, 34); end
          1: begin proto = ipv4l4_pkg::PROTO_UDP; len = $urandom_range(41, 34); end
          2: begin proto = 8'($urandom_range(255)); len = $urandom_range(33, 14); end
          default: begin proto = 8'($urandom_range(255)); len = $urandom_range(13, 1); end
        endcase
      end else begin
        len   = $urandom_range(64, 1);
        etype = ($urandom_range(1) == 0) ? ipv4l4_pkg::ETHERTYPE_IPV4
                                         : 16'($urandom_range(16'hFFFF));
        case ($urandom_range(2))
          0:       proto = ipv4l4_pkg::PROTO_TCP;
          1:       proto = ipv4l4_pkg::PROTO_UDP;
          default: proto = 8'($urandom_range(255));
        endcase
      end
      send_frame(len, etype, proto, FILL_RANDOM);
      sent += len;
    end
  endtask

  initial begin
    rst           = 1'b1;
    hold_req      = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = 8'h00;
    s_axis_tlast  = 1'b0;
    send_idle_pct = 33;
    recv_idle_pct = 75;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_frame(1,  ipv4l4_pkg::ETHERTYPE_IPV4, ipv4l4_pkg::PROTO_TCP, FILL_RANDOM);
    send_frame(13, ipv4l4_pkg::ETHERTYPE_IPV4, ipv4l4_pkg::PROTO_TCP, FILL_RANDOM);
    send_frame(14, 16'h86DD,                   ipv4l4_pkg::PROTO_TCP, FILL_RANDOM);
    send_frame(14, ipv4l4_pkg::ETHERTYPE_IPV4, ipv4l4_pkg::PROTO_TCP, FILL_RANDOM);
    send_frame(33, ipv4l4_pkg::ETHERTYPE_IPV4, ipv4l4_pkg::PROTO_TCP, FILL_RANDOM);
    send_frame(34, ipv4l4_pkg::ETHERTYPE_IPV4, 8'd1,                  FILL_RANDOM);
    send_frame(34, ipv4l4_pkg::ETHERTYPE_IPV4, ipv4l4_pkg::PROTO_UDP, FILL_RANDOM);
    send_frame(41, ipv4l4_pkg::ETHERTYPE_IPV4, ipv4l4_pkg::PROTO_UDP, FILL_RANDOM);
    send_frame(42, ipv4l4_pkg::ETHERTYPE_IPV4, ipv4l4_pkg::PROTO_UDP, FILL_ONES);
    send_frame(53, ipv4l4_pkg::ETHERTYPE_IPV4, ipv4l4_pkg::PROTO_TCP, FILL_RANDOM);
    send_frame(54, ipv4l4_pkg::ETHERTYPE_IPV4, ipv4l4_pkg::PROTO_TCP, FILL_ONES);
    send_frame(54, ipv4l4_pkg::ETHERTYPE_IPV4, ipv4l4_pkg::PROTO_TCP, FILL_ZERO);
    send_frame(72, ipv4l4_pkg::ETHERTYPE_IPV4, ipv4l4_pkg::PROTO_TCP, FILL_RANDOM);
    send_frame(60, 16'h0000,                   ipv4l4_pkg::PROTO_TCP, FILL_ZERO);
    send_frame(60, 16'hFFFF,                   ipv4l4_pkg::PROTO_UDP, FILL_ONES);
    send_frame(40, 16'h0801,                   ipv4l4_pkg::PROTO_UDP, FILL_RANDOM);
    send_frame(70, ipv4l4_pkg::ETHERTYPE_IPV4, 8'hFF,                 FILL_ONES);
    send_frame(34, ipv4l4_pkg::ETHERTYPE_IPV4, 8'h00,                 FILL_ZERO);
    drain();

    send_random_frames(160);
    drain();

    send_idle_pct = 75;
    recv_idle_pct = 33;
    send_random_frames(160);
    drain();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_req <= 1'b1;
    send_random_frames(160);
    drain();

    repeat (8) @(posedge clk);
    if (mismatch_count == 0 && results_outstanding == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

@@ ipv4_l4_header_extractor_core.f @@
design/ipv4l4_pkg.sv
design/ipv4_l4_header_extractor_core.sv
tb/ipv4_l4_result_monitor.sv
tb/testbench.sv
